>>> design/lpfr_pkg.sv
// shared types and codes for the length-prefixed frame reassembler
package lpfr_pkg;

  // packet commands
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_DATA    = 2'd1,
    CMD_ABANDON = 2'd2
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_COMPLETE = 3'd0,
    ST_AGAIN    = 3'd1,
    ST_BADLEN   = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_ORPHAN   = 3'd4
  } status_t;

  // reassembly state carried between packets
  typedef struct packed {
    logic [15:0] expected_length;
    logic [15:0] bytes_have;
    logic [31:0] truncated_count;
    logic [31:0] orphan_count;
  } asm_state_t;

  // one result beat
  typedef struct packed {
    status_t     status;
    logic        write_valid;
    logic [15:0] write_offset;
    logic [3:0]  write_count;
    logic [63:0] write_data;
    logic [15:0] frame_length;
    logic [31:0] truncated_total;
    logic [31:0] orphan_total;
  } result_t;

  localparam logic [15:0] CAPACITY_RESET = 16'd1024;

endpackage

>>> design/lpfr_step.sv
// per-packet reassembly logic: next state and result from one packet
module lpfr_step #(
  parameter int PAYLOAD_BYTES = 8,
  parameter int HEADER_BYTES  = 4,
  parameter int MAX_FRAME     = 1024
) (
  input  lpfr_pkg::asm_state_t state,
  input  logic [15:0]          capacity,
  input  logic [1:0]           cmd,
  input  logic [3:0]           payload_len,
  input  logic [63:0]          payload,
  output lpfr_pkg::asm_state_t state_next,
  output lpfr_pkg::result_t    result
);
  import lpfr_pkg::*;

  localparam logic [3:0]  PayMax   = 4'(PAYLOAD_BYTES);
  localparam logic [15:0] HdrMin   = 16'(HEADER_BYTES);
  localparam logic [15:0] FrameMax = 16'(MAX_FRAME);

  logic [15:0] total;
  logic        frame_open;
  logic        len_bad;
  logic [3:0]  plen_sat;
  logic [15:0] remaining;
  logic [3:0]  take;
  logic [15:0] have_sum;
  logic [63:0] data_masked;

  // start length checks
  assign total      = payload[15:0];
  assign frame_open = (state.expected_length != 16'd0);
  assign len_bad    = (total < HdrMin) || (total > capacity) || (total > FrameMax);

  // clip data to bytes still owed
  assign plen_sat  = (payload_len > PayMax) ? PayMax : payload_len;
  assign remaining = state.expected_length - state.bytes_have;
  assign take      = (remaining < {12'd0, plen_sat}) ? remaining[3:0] : plen_sat;
  assign have_sum  = state.bytes_have + {12'd0, take};

  // zero the bytes beyond the write count
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      data_masked[8*i +: 8] = (4'(i) < take) ? payload[8*i +: 8] : 8'd0;
    end
  end

  // command decode
  always_comb begin
    state_next = state;
    result     = '0;
    result.status = ST_AGAIN;
    case (cmd_t'(cmd))
      CMD_START: begin
        if (frame_open) begin
          state_next.truncated_count = state.truncated_count + 32'd1;
        end
        state_next.bytes_have = 16'd0;
        if (len_bad) begin
          state_next.expected_length = 16'd0;
          result.status = ST_BADLEN;
        end else begin
          state_next.expected_length = total;
          result.status = frame_open ? ST_TRUNC : ST_AGAIN;
        end
      end
      CMD_DATA: begin
        if (!frame_open) begin
          state_next.orphan_count = state.orphan_count + 32'd1;
          result.status = ST_ORPHAN;
        end else begin
          if (take != 4'd0) begin
            result.write_valid  = 1'b1;
            result.write_offset = state.bytes_have;
            result.write_count  = take;
            result.write_data   = data_masked;
          end
          if (have_sum < state.expected_length) begin
            state_next.bytes_have = have_sum;
            result.status = ST_AGAIN;
          end else begin
            state_next.expected_length = 16'd0;
            state_next.bytes_have      = 16'd0;
            result.frame_length = state.expected_length;
            result.status = ST_COMPLETE;
          end
        end
      end
      CMD_ABANDON: begin
        state_next.expected_length = 16'd0;
        state_next.bytes_have      = 16'd0;
      end
      default: begin
        state_next = state;
      end
    endcase
    result.truncated_total = state_next.truncated_count;
    result.orphan_total    = state_next.orphan_count;
  end

endmodule

>>> design/length_prefixed_frame_reassembler_unit.sv
// Length-prefixed frame reassembler. Takes one relay packet per cycle and gives
// one result beat per packet. The packet is held in an input register. The
// reassembly logic works on it against the frame state, and the result lands
// in an output register, from which the result beat is offered. The frame
// state register closes its loop through that logic alone, so packets follow
// back to back while the output side keeps taking beats. A stalled result
// holds the input register and then the input side. The buffer capacity
// register is to be written through cfg_we/cfg_wdata only while idle; the
// block itself does not enforce this.
module length_prefixed_frame_reassembler_unit #(
  parameter int PAYLOAD_BYTES = 8,
  parameter int HEADER_BYTES  = 4,
  parameter int MAX_FRAME     = 1024
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  // packet input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [3:0]        payload_len,
  input  logic [63:0]       payload,
  // result output
  output logic              out_valid,
  input  logic              out_stall,
  output lpfr_pkg::status_t status,
  output logic              write_valid,
  output logic [15:0]       write_offset,
  output logic [3:0]        write_count,
  output logic [63:0]       write_data,
  output logic [15:0]       frame_length,
  output logic [31:0]       truncated_total,
  output logic [31:0]       orphan_total
);
  import lpfr_pkg::*;

  logic        buffer_capacity;
  logic [15:0] capacity;
  asm_state_t  state;
  asm_state_t  state_next;
  result_t     step_result;
  result_t     result;
  logic        pkt_valid;
  logic [1:0]  pkt_cmd;
  logic [3:0]  pkt_len;
  logic [63:0] pkt_payload;
  logic        out_free;
  logic        advance;

  // handshake
  assign out_free = !out_valid || !out_stall;
  assign advance  = pkt_valid && out_free;
  assign in_stall = pkt_valid && !out_free;
  assign buffer_capacity = cfg_we;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (buffer_capacity) begin
      capacity <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
    end else if (!in_stall) begin
      pkt_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      pkt_cmd     <= cmd;
      pkt_len     <= payload_len;
      pkt_payload <= payload;
    end
  end

  // reassembly logic
  lpfr_step #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_FRAME    (MAX_FRAME)
  ) u_step (
    .state      (state),
    .capacity   (capacity),
    .cmd        (pkt_cmd),
    .payload_len(pkt_len),
    .payload    (pkt_payload),
    .state_next (state_next),
    .result     (step_result)
  );

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pkt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign status          = result.status;
  assign write_valid     = result.write_valid;
  assign write_offset    = result.write_offset;
  assign write_count     = result.write_count;
  assign write_data      = result.write_data;
  assign frame_length    = result.frame_length;
  assign truncated_total = result.truncated_total;
  assign orphan_total    = result.orphan_total;

endmodule

>>> design/lpfr_checker.sv
// port-level checks for the frame reassembler, bound to the top level
module lpfr_checker #(
  parameter int PAYLOAD_BYTES = 8
) (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input lpfr_pkg::status_t status,
  input logic              write_valid,
  input logic [15:0]       write_offset,
  input logic [3:0]        write_count,
  input logic [63:0]       write_data,
  input logic [15:0]       frame_length
);
  import lpfr_pkg::*;

  localparam logic [3:0] PayMax = 4'(PAYLOAD_BYTES);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(write_data))
    else $error("result beat changed while stalled");

  // no write fields without a write
  a_idle_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_valid |->
      write_count == 4'd0 && write_offset == 16'd0 && write_data == 64'd0)
    else $error("write fields set without a write");

  // a write moves between one and a full packet of bytes
  a_write_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid |-> write_count != 4'd0 && write_count <= PayMax)
    else $error("write count out of range");

  // frame length only on completion
  a_frame_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_COMPLETE |-> frame_length == 16'd0)
    else $error("frame length without completion");

endmodule

bind length_prefixed_frame_reassembler_unit lpfr_checker #(
  .PAYLOAD_BYTES(PAYLOAD_BYTES)
) u_lpfr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .write_valid (write_valid),
  .write_offset(write_offset),
  .write_count (write_count),
  .write_data  (write_data),
  .frame_length(frame_length)
);

>>> tb/sv/tb.sv
// self-checking testbench for the length-prefixed frame reassembler unit
module tb;
  import lpfr_pkg::*;

  localparam int PAYLOAD_BYTES = 8;
  localparam int HEADER_BYTES  = 4;
  localparam int MAX_FRAME     = 1024;
  localparam int QUIET_LIMIT   = 3000;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AFTER    = 800;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // one row of the directed packet table
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  len;
    logic [63:0] data;
    logic        typed;
    result_t     want;
  } packet_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [3:0]  payload_len;
  logic [63:0] payload;
  logic        out_valid;
  logic        out_stall;
  status_t     status;
  logic        write_valid;
  logic [15:0] write_offset;
  logic [3:0]  write_count;
  logic [63:0] write_data;
  logic [15:0] frame_length;
  logic [31:0] truncated_total;
  logic [31:0] orphan_total;

  // reassembly state as the testbench sees it
  logic [15:0] buf_capacity;
  logic [15:0] frame_total;
  logic [15:0] frame_have;
  logic [31:0] cut_count;
  logic [31:0] stray_count;

  result_t     owed_beats[$];
  packet_row_t dir_rows[$];
  int          errors = 0;
  int          items_taken = 0;
  int          quiet_cycles = 0;
  bit          steady = 1'b0;
  bit          hold_done = 1'b0;

  length_prefixed_frame_reassembler_unit #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_FRAME    (MAX_FRAME)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .payload_len    (payload_len),
    .payload        (payload),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .write_valid    (write_valid),
    .write_offset   (write_offset),
    .write_count    (write_count),
    .write_data     (write_data),
    .frame_length   (frame_length),
    .truncated_total(truncated_total),
    .orphan_total   (orphan_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // reassembly of one packet against the tracked frame state
  function automatic result_t reassemble(input logic [1:0] op, input logic [3:0] len,
                                         input logic [63:0] data);
    result_t     r;
    logic [15:0] total;
    logic [15:0] owed;
    logic [3:0]  usable;
    logic [3:0]  take;
    logic        interrupted;
    r = '0;
    r.status = ST_AGAIN;
    case (op)
      CMD_START: begin
        total = data[15:0];
        interrupted = (frame_total != 16'd0);
        if (interrupted) cut_count = cut_count + 32'd1;
        frame_total = 16'd0;
        frame_have = 16'd0;
        if (total < HEADER_BYTES || total > buf_capacity || total > MAX_FRAME) begin
          r.status = ST_BADLEN;
        end else begin
          frame_total = total;
          r.status = interrupted ? ST_TRUNC : ST_AGAIN;
        end
      end
      CMD_DATA: begin
        if (frame_total == 16'd0) begin
          stray_count = stray_count + 32'd1;
          r.status = ST_ORPHAN;
        end else begin
          owed = frame_total - frame_have;
          usable = (len > PAYLOAD_BYTES) ? 4'(PAYLOAD_BYTES) : len;
          take = (owed < 16'(usable)) ? owed[3:0] : usable;
          if (take != 4'd0) begin
            r.write_valid = 1'b1;
            r.write_offset = frame_have;
            r.write_count = take;
            r.write_data = (take >= 4'd8) ? data
                                          : data & ((64'd1 << (8 * take)) - 64'd1);
          end
          frame_have = frame_have + 16'(take);
          if (frame_have < frame_total) begin
            r.status = ST_AGAIN;
          end else begin
            r.status = ST_COMPLETE;
            r.frame_length = frame_total;
            frame_total = 16'd0;
            frame_have = 16'd0;
          end
        end
      end
      CMD_ABANDON: begin
        frame_total = 16'd0;
        frame_have = 16'd0;
      end
      default: ;
    endcase
    r.truncated_total = cut_count;
    r.orphan_total = stray_count;
    return r;
  endfunction

  function automatic result_t beat(input status_t s, input logic wv, input logic [15:0] off,
                                   input logic [3:0] n, input logic [63:0] d,
                                   input logic [15:0] fl, input logic [31:0] tr,
                                   input logic [31:0] orp);
    result_t r;
    r = '{s, wv, off, n, d, fl, tr, orp};
    return r;
  endfunction

  // mostly no gap, sometimes a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // offer one packet, hold it until taken, then log its expected beat
  task automatic send_packet(input logic [1:0] op, input logic [3:0] len,
                             input logic [63:0] data, input logic typed, input result_t want);
    int      gap;
    result_t predicted;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    payload_len <= len;
    payload <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = reassemble(op, len, data);
    owed_beats.push_back(typed ? want : predicted);
    items_taken++;
  endtask

  task automatic send_random(input logic [1:0] op, input logic [3:0] len,
                             input logic [63:0] data);
    send_packet(op, len, data, 1'b0, '0);
  endtask

  // let every expected beat come back, then write the capacity register
  task automatic set_capacity(input logic [15:0] value);
    in_valid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    buf_capacity = value;
  endtask

  // frame length: mostly short, some long, a few out of range
  function automatic logic [15:0] pick_length();
    int lim;
    int r;
    lim = (buf_capacity < MAX_FRAME) ? int'(buf_capacity) : MAX_FRAME;
    r = $urandom_range(0, 99);
    if (lim < HEADER_BYTES) return 16'($urandom_range(0, 65535));
    if (r < 3) return 16'($urandom_range(0, HEADER_BYTES - 1));
    if (r < 6) return 16'($urandom_range(lim + 1, 65535));
    if (r < 75) return 16'($urandom_range(HEADER_BYTES, (lim < 40) ? lim : 40));
    if (r < 96) return 16'($urandom_range(HEADER_BYTES, (lim < 200) ? lim : 200));
    return 16'($urandom_range(HEADER_BYTES, lim));
  endfunction

  function automatic logic [3:0] pick_len();
    return ($urandom_range(0, 99) < 80) ? 4'd8 : 4'($urandom_range(0, 15));
  endfunction

  // one start followed by its data beats, with the odd stray packet around it
  task automatic run_frame();
    logic [63:0] head;
    int          r;
    steady = ($urandom_range(0, 99) < 15);
    r = $urandom_range(0, 99);
    if (r < 4) send_random(CMD_DATA, 4'($urandom_range(0, 15)), rand_word());
    else if (r < 6) send_random(CMD_ABANDON, 4'($urandom_range(0, 15)), rand_word());
    else if (r < 8) send_random(CMD_UNUSED, 4'($urandom_range(0, 15)), rand_word());
    head = rand_word();
    head[15:0] = pick_length();
    send_random(CMD_START, 4'($urandom_range(0, 15)), head);
    while (frame_total != 16'd0) begin
      r = $urandom_range(0, 199);
      if (r < 2) begin
        // leave it open so the next start cuts it short
        return;
      end else if (r < 4) begin
        send_random(CMD_ABANDON, 4'($urandom_range(0, 15)), rand_word());
        return;
      end else if (r < 6) begin
        send_random(CMD_UNUSED, 4'($urandom_range(0, 15)), rand_word());
      end else begin
        send_random(CMD_DATA, pick_len(), rand_word());
      end
    end
  endtask

  // check a taken result beat against the oldest expectation
  task automatic check_beat();
    result_t want;
    if (owed_beats.size() == 0) begin
      $error("result beat with no packet waiting");
      errors++;
      return;
    end
    want = owed_beats.pop_front();
    if (status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, status);
      errors++;
    end
    if (write_valid !== want.write_valid) begin
      $error("write_valid: expected %0d, got %0d", want.write_valid, write_valid);
      errors++;
    end
    if (write_offset !== want.write_offset) begin
      $error("write_offset: expected %0d, got %0d", want.write_offset, write_offset);
      errors++;
    end
    if (write_count !== want.write_count) begin
      $error("write_count: expected %0d, got %0d", want.write_count, write_count);
      errors++;
    end
    if (write_data !== want.write_data) begin
      $error("write_data: expected %h, got %h", want.write_data, write_data);
      errors++;
    end
    if (frame_length !== want.frame_length) begin
      $error("frame_length: expected %0d, got %0d", want.frame_length, frame_length);
      errors++;
    end
    if (truncated_total !== want.truncated_total) begin
      $error("truncated_total: expected %0d, got %0d", want.truncated_total,
             truncated_total);
      errors++;
    end
    if (orphan_total !== want.orphan_total) begin
      $error("orphan_total: expected %0d, got %0d", want.orphan_total, orphan_total);
      errors++;
    end
  endtask

  // result side: take beats, stall at random, one long hold-off mid-run
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) check_beat();
      if (!hold_done && items_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !steady) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles where neither side moves a beat
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // packet side: directed table, then random phases at several capacities
  initial begin : packet_side
    logic [15:0] phase_cap[6];
    int          phase_items[6];
    int          phase_end;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 16'd0;
    in_valid = 1'b0;
    cmd = CMD_ABANDON;
    payload_len = 4'd0;
    payload = 64'd0;
    buf_capacity = CAPACITY_RESET;
    frame_total = 16'd0;
    frame_have = 16'd0;
    cut_count = 32'd0;
    stray_count = 32'd0;

    dir_rows = '{
      // stray data with nothing open, then lengths out of range
      '{CMD_DATA,   4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        beat(ST_ORPHAN, 0, 0, 0, 0, 0, 0, 1)},
      '{CMD_START,  4'd0,  64'h0000_0000_0000_0003, 1'b1,
        beat(ST_BADLEN, 0, 0, 0, 0, 0, 0, 1)},
      '{CMD_START,  4'd15, 64'hFFFF_FFFF_FFFF_0401, 1'b1,
        beat(ST_BADLEN, 0, 0, 0, 0, 0, 0, 1)},
      '{CMD_START,  4'd0,  64'h0000_0000_0000_FFFF, 1'b1,
        beat(ST_BADLEN, 0, 0, 0, 0, 0, 0, 1)},
      // shortest frame, finished by one oversized beat
      '{CMD_START,  4'd0,  64'hFFFF_FFFF_FFFF_0004, 1'b1,
        beat(ST_AGAIN, 0, 0, 0, 0, 0, 0, 1)},
      '{CMD_DATA,   4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        beat(ST_COMPLETE, 1, 0, 4, 64'hFFFF_FFFF, 4, 0, 1)},
      // longest frame, an empty beat, then cut short by a new start
      '{CMD_START,  4'd0,  64'h0000_0000_0000_0400, 1'b1,
        beat(ST_AGAIN, 0, 0, 0, 0, 0, 0, 1)},
      '{CMD_DATA,   4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        beat(ST_AGAIN, 0, 0, 0, 0, 0, 0, 1)},
      '{CMD_DATA,   4'd8,  64'h0123_4567_89AB_CDEF, 1'b0, '0},
      '{CMD_DATA,   4'd9,  64'hA5A5_5A5A_C3C3_3C3C, 1'b0, '0},
      '{CMD_START,  4'd0,  64'h0000_0000_0000_0014, 1'b1,
        beat(ST_TRUNC, 0, 0, 0, 0, 0, 1, 1)},
      '{CMD_DATA,   4'd3,  64'hFEDC_BA98_7654_3210, 1'b0, '0},
      '{CMD_DATA,   4'd8,  64'h1122_3344_5566_7788, 1'b0, '0},
      // bad length on an open frame still counts the cut
      '{CMD_START,  4'd0,  64'h0000_0000_0000_0002, 1'b1,
        beat(ST_BADLEN, 0, 0, 0, 0, 0, 2, 1)},
      '{CMD_DATA,   4'd5,  64'h0F0F_0F0F_0F0F_0F0F, 1'b1,
        beat(ST_ORPHAN, 0, 0, 0, 0, 0, 2, 2)},
      // abandon, then the unused command on a closed and an open frame
      '{CMD_START,  4'd0,  64'h8000_0000_0000_000A, 1'b0, '0},
      '{CMD_ABANDON, 4'd8, 64'hDEAD_BEEF_0000_0010, 1'b0, '0},
      '{CMD_DATA,   4'd4,  64'h0000_0000_CAFE_F00D, 1'b0, '0},
      '{CMD_UNUSED, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{CMD_START,  4'd0,  64'h0000_0000_0000_0009, 1'b0, '0},
      '{CMD_UNUSED, 4'd8,  64'h0000_0000_0000_0000, 1'b0, '0},
      '{CMD_DATA,   4'd8,  64'h0000_0000_0000_0000, 1'b0, '0},
      '{CMD_DATA,   4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{CMD_ABANDON, 4'd0, 64'h0000_0000_0000_0000, 1'b0, '0},
      '{CMD_START,  4'd0,  64'h0000_0000_0000_0000, 1'b0, '0}
    };

    phase_cap = '{16'hFFFF, 16'd0, 16'd4, 16'd1024, 16'($urandom_range(4, 1100)), 16'd17};
    phase_items = '{500, 60, 150, 550, 400, 300};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table at the reset capacity
    foreach (dir_rows[i])
      send_packet(dir_rows[i].op, dir_rows[i].len, dir_rows[i].data,
                  dir_rows[i].typed, dir_rows[i].want);

    // random phases, each after an idle capacity write
    foreach (phase_cap[p]) begin
      set_capacity(phase_cap[p]);
      phase_end = items_taken + phase_items[p];
      while (items_taken < phase_end) run_frame();
    end

    // drain and settle
    steady = 1'b0;
    in_valid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> length_prefixed_frame_reassembler_unit.f
design/lpfr_pkg.sv
design/lpfr_step.sv
design/length_prefixed_frame_reassembler_unit.sv
design/lpfr_checker.sv
tb/sv/tb.sv
